>>> rtl/core/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg
// shared types, widths and helpers for the point/plane side test
// ----------------------------------------------------------------------------
package ppst_pkg;

   localparam int COORD_W       = 32;
   localparam int SQ_W          = 64;
   localparam int MAG_W         = 63;
   localparam int LEN_W         = 33;
   localparam int ROOT_W        = 32;
   localparam int EPS_W         = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [15:0] EPS_RESET = 16'd1;

   typedef enum logic [1:0] {
      SIDE_ON  = 2'd0,
      SIDE_POS = 2'd1,
      SIDE_NEG = 2'd2
   } side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
   } query_type;

   // front end result: squared length, dot magnitude and sign
   typedef struct packed {
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [SQ_W-1:0]  sq;
   } front_type;

   // after the root: length replaces the squared length
   typedef struct packed {
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [LEN_W-1:0] len;
   } root_type;

   typedef struct packed {
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] qmag;
   } quot_type;

   // 32-bit difference clamped to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] diff_clamp(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[COORD_W] != d[COORD_W-1]) begin
         diff_clamp = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         diff_clamp = d[COORD_W-1:0];
      end
   endfunction

   // add two signed 64-bit values, saturate to +-(2^63-1)
   function automatic logic signed [63:0] sat_add(
      input logic signed [63:0] a,
      input logic signed [63:0] b
   );
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat_add = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat_add = -64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         sat_add = s[63:0];
      end
   endfunction

endpackage

>>> rtl/core/ppst_req_if.sv
// ----------------------------------------------------------------------------
// ppst_req_if
// query word channel: point, vertex and normal with valid/ready
// ----------------------------------------------------------------------------
interface ppst_req_if
   import ppst_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic signed [COORD_W-1:0] vertex_z;
   logic signed [COORD_W-1:0] normal_x;
   logic signed [COORD_W-1:0] normal_y;
   logic signed [COORD_W-1:0] normal_z;

   modport source (
      output valid, point_x, point_y, point_z, vertex_x, vertex_y, vertex_z,
             normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, point_z, vertex_x, vertex_y, vertex_z,
             normal_x, normal_y, normal_z,
      output ready
   );
endinterface

>>> rtl/core/ppst_rsp_if.sv
// ----------------------------------------------------------------------------
// ppst_rsp_if
// result word channel: side code with valid/ready
// ----------------------------------------------------------------------------
interface ppst_rsp_if
   import ppst_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] side;

   modport source (output valid, side, input ready);
   modport sink   (input valid, side, output ready);
endinterface

>>> rtl/core/ppst_front.sv
// ----------------------------------------------------------------------------
// ppst_front
// offset, products, squared length and saturating dot product (5 stages)
// ----------------------------------------------------------------------------
module ppst_front
   import ppst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  query_type in_query,
   output logic      out_valid,
   output front_type out_data
);

   // stage 1: clamped offsets
   logic                      s1_valid_ff;
   logic signed [COORD_W-1:0] v_ff [3];
   logic signed [COORD_W-1:0] n_ff [3];
   // stage 2: products
   logic                      s2_valid_ff;
   logic                      s2_zero_ff;
   logic [SQ_W-1:0]           sqp_ff [3];
   logic signed [63:0]        dp_ff [3];
   // stage 3: partial sums
   logic                      s3_valid_ff;
   logic                      s3_zero_ff;
   logic [SQ_W-1:0]           s3_sq_ff;
   logic signed [63:0]        s3_dot_ff;
   logic signed [63:0]        s3_p2_ff;
   // stage 4: full dot
   logic                      s4_valid_ff;
   logic                      s4_zero_ff;
   logic [SQ_W-1:0]           s4_sq_ff;
   logic signed [63:0]        s4_dot_ff;
   // stage 5: sign and magnitude
   logic                      s5_valid_ff;
   front_type                 s5_ff;

   logic signed [63:0]        s4_dot_in;
   logic signed [63:0]        abs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   assign s4_dot_in = sat_add(s3_dot_ff, s3_p2_ff);
   assign abs_in    = s4_dot_ff[63] ? -s4_dot_ff : s4_dot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0] <= diff_clamp(in_query.point_x, in_query.vertex_x);
         v_ff[1] <= diff_clamp(in_query.point_y, in_query.vertex_y);
         v_ff[2] <= diff_clamp(in_query.point_z, in_query.vertex_z);
         n_ff[0] <= in_query.normal_x;
         n_ff[1] <= in_query.normal_y;
         n_ff[2] <= in_query.normal_z;

         s2_zero_ff <= (v_ff[0] == '0) && (v_ff[1] == '0) && (v_ff[2] == '0);
         for (int i = 0; i < 3; i++) begin
            sqp_ff[i] <= SQ_W'(64'(v_ff[i]) * 64'(v_ff[i]));
            dp_ff[i]  <= 64'(v_ff[i]) * 64'(n_ff[i]);
         end

         // each square is at most 2^62, so the sum fits 64 bits
         s3_zero_ff <= s2_zero_ff;
         s3_sq_ff   <= sqp_ff[0] + sqp_ff[1] + sqp_ff[2];
         s3_dot_ff  <= sat_add(dp_ff[0], dp_ff[1]);
         s3_p2_ff   <= dp_ff[2];

         s4_zero_ff <= s3_zero_ff;
         s4_sq_ff   <= s3_sq_ff;
         s4_dot_ff  <= s4_dot_in;

         s5_ff.zero <= s4_zero_ff;
         s5_ff.neg  <= s4_dot_ff[63];
         s5_ff.mag  <= abs_in[MAG_W-1:0];
         s5_ff.sq   <= s4_sq_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_ff;

endmodule

>>> rtl/core/ppst_isqrt.sv
// ----------------------------------------------------------------------------
// ppst_isqrt
// floor square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module ppst_isqrt
   import ppst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output root_type  out_data
);

   localparam int STEPS = ROOT_W;

   logic                    valid_ff [STEPS+1];
   logic [SQ_W-1:0]         n_ff     [STEPS+1];
   logic [ROOT_W:0]         rem_ff   [STEPS+1];
   logic [ROOT_W-1:0]       root_ff  [STEPS+1];
   logic                    zero_ff  [STEPS+1];
   logic                    neg_ff   [STEPS+1];
   logic [MAG_W-1:0]        mag_ff   [STEPS+1];

   assign valid_ff[0] = in_valid;
   assign n_ff[0]     = in_data.sq;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign zero_ff[0]  = in_data.zero;
   assign neg_ff[0]   = in_data.neg;
   assign mag_ff[0]   = in_data.mag;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [ROOT_W+2:0] rem_sh;
      logic [ROOT_W+2:0] trial;
      logic              take;

      assign rem_sh = {rem_ff[j], n_ff[j][SQ_W-1 -: 2]};
      assign trial  = {1'b0, root_ff[j], 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end

      // remainder is at most twice the root, so it needs ROOT_W+1 bits
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[j+1]    <= {n_ff[j][SQ_W-3:0], 2'b00};
            rem_ff[j+1]  <= take ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            root_ff[j+1] <= {root_ff[j][ROOT_W-2:0], take};
            zero_ff[j+1] <= zero_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            mag_ff[j+1]  <= mag_ff[j];
         end
      end
   end

   assign out_valid     = valid_ff[STEPS];
   assign out_data.zero = zero_ff[STEPS];
   assign out_data.neg  = neg_ff[STEPS];
   assign out_data.mag  = mag_ff[STEPS];
   assign out_data.len  = {1'b0, root_ff[STEPS]};

endmodule

>>> rtl/core/ppst_div.sv
// ----------------------------------------------------------------------------
// ppst_div
// restoring divide of dot magnitude by length, one quotient bit per stage
// ----------------------------------------------------------------------------
module ppst_div
   import ppst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  root_type in_data,
   output logic     out_valid,
   output quot_type out_data
);

   localparam int STEPS = MAG_W;
   localparam int REM_W = LEN_W - 1;

   logic               valid_ff [STEPS+1];
   logic [MAG_W-1:0]   num_ff   [STEPS+1];
   logic [MAG_W-1:0]   quo_ff   [STEPS+1];
   logic [REM_W-1:0]   rem_ff   [STEPS+1];
   logic [LEN_W-1:0]   len_ff   [STEPS+1];
   logic               zero_ff  [STEPS+1];
   logic               neg_ff   [STEPS+1];

   assign valid_ff[0] = in_valid;
   assign num_ff[0]   = in_data.mag;
   assign quo_ff[0]   = '0;
   assign rem_ff[0]   = '0;
   assign len_ff[0]   = in_data.len;
   assign zero_ff[0]  = in_data.zero;
   assign neg_ff[0]   = in_data.neg;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [LEN_W-1:0] rem_sh;
      logic             take;

      // remainder stays below the length, so it fits REM_W bits
      assign rem_sh = {rem_ff[j], num_ff[j][MAG_W-1]};
      assign take   = rem_sh >= len_ff[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[j+1]  <= {num_ff[j][MAG_W-2:0], 1'b0};
            quo_ff[j+1]  <= {quo_ff[j][MAG_W-2:0], take};
            rem_ff[j+1]  <= take ? REM_W'(rem_sh - len_ff[j]) : rem_sh[REM_W-1:0];
            len_ff[j+1]  <= len_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
         end
      end
   end

   assign out_valid     = valid_ff[STEPS];
   assign out_data.zero = zero_ff[STEPS];
   assign out_data.neg  = neg_ff[STEPS];
   assign out_data.qmag = quo_ff[STEPS];

endmodule

>>> rtl/core/point_plane_side_test_core.sv
// ----------------------------------------------------------------------------
// point_plane_side_test_core
// classifies a query point against a triangle plane
// ----------------------------------------------------------------------------
// usage:
//  - req carries one query word: point, first vertex and plane normal,
//    all signed fixed point with FRAC_BITS fraction bits
//  - rsp returns one side word per query, in order: on, positive, negative
//  - csr_we/csr_wdata set the on-plane tolerance epsilon (Q0.16), reset 1;
//    the user must write it only while no query is in flight; not enforced
// stages from req accept to rsp valid:
//  - 5 front stages (offset, products, sums, saturation, magnitude)
//  - 32 root stages, one root bit each
//  - 63 divide stages, one quotient bit each
//  - 1 compare stage, 1 output register
// throughput: one word per cycle unless rsp stalls (bit-per-stage pipeline)
// reset clears all valid bits, including output and skid valid, and reloads
// epsilon; payload registers are not reset
// when rsp stalls the output register holds, one more word drops into the
// skid register, and req.ready falls until the skid drains
// ----------------------------------------------------------------------------
module point_plane_side_test_core
   import ppst_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ppst_req_if.sink          req,
   ppst_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic [EPS_W-1:0]  csr_wdata
);

   // tolerance scaled to FRAC_BITS
   localparam int EPSF_W = (FRAC_BITS >= 16) ? FRAC_BITS : 16;
   localparam int EPS_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int EPS_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

   logic [EPS_W-1:0]   eps_ff;
   logic [EPSF_W-1:0]  eps_scaled;

   // pipeline advance: stops only once the skid is holding a word
   logic               en;
   query_type          query;
   logic               front_valid;
   front_type          front_data;
   logic               root_valid;
   root_type           root_data;
   logic               quot_valid;
   quot_type           quot_data;

   // compare stage
   logic               cmp_valid_ff;
   side_type           cmp_side_ff;
   side_type           cmp_side_in;
   logic               over;

   // output register and skid
   logic               out_valid_ff;
   side_type           out_side_ff;
   logic               skid_valid_ff;
   side_type           skid_side_ff;
   logic               hand;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   assign eps_scaled = (EPSF_W'(eps_ff) << EPS_SHL) >> EPS_SHR;

   assign en        = !skid_valid_ff;
   assign req.ready = en;

   assign query.point_x  = req.point_x;
   assign query.point_y  = req.point_y;
   assign query.point_z  = req.point_z;
   assign query.vertex_x = req.vertex_x;
   assign query.vertex_y = req.vertex_y;
   assign query.vertex_z = req.vertex_z;
   assign query.normal_x = req.normal_x;
   assign query.normal_y = req.normal_y;
   assign query.normal_z = req.normal_z;

   ppst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .in_query  (query),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   ppst_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   ppst_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .out_valid (quot_valid),
      .out_data  (quot_data)
   );

   // |q| above epsilon decides the side, its sign says which
   assign over = quot_data.qmag > MAG_W'(eps_scaled);

   always_comb begin
      if (quot_data.zero || !over) begin
         cmp_side_in = SIDE_ON;
      end else if (quot_data.neg) begin
         cmp_side_in = SIDE_NEG;
      end else begin
         cmp_side_in = SIDE_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else if (en) begin
         cmp_valid_ff <= quot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_side_ff <= cmp_side_in;
      end
   end

   // word leaves the compare stage
   assign hand = en && cmp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= hand;
         end
      end else if (hand) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp.ready) begin
         out_side_ff <= skid_valid_ff ? skid_side_ff : cmp_side_ff;
      end
      if (hand) begin
         skid_side_ff <= cmp_side_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.side  = out_side_ff;

   // skid only fills behind a stalled output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output is empty");

   // a stalled output word is never dropped
   a_out_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> out_valid_ff)
      else $error("stalled output word lost");

   // a full skid must stop the pipeline
   a_stop_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !en)
      else $error("pipeline advancing with a full skid");

endmodule
